// ----- hdl/last_axis_to_second_transpose_addr_core_macros.svh -----
// Assertion macros for the channels-last to channels-first address core.
// Used by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef LAST_AXIS_TO_SECOND_TRANSPOSE_ADDR_CORE_MACROS_SVH
`define LAST_AXIS_TO_SECOND_TRANSPOSE_ADDR_CORE_MACROS_SVH

// check that is off while reset is high
`define LSTTR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check that also holds through reset
`define LSTTR_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hdl/lsttr_pkg.sv -----
// Shared types, constants and helpers for the transpose address core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lsttr_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int EXTENT_WIDTH  = 16;
  localparam int NUM_AXES      = 6;
  localparam int INDEX_WIDTH   = 32;
  localparam int WORD_WIDTH    = 32;
  localparam int CFG_WIDTH     = 16;
  localparam int TOTAL_WIDTH   = INDEX_WIDTH + 1;

  typedef logic [EXTENT_WIDTH-1:0] ext_t;
  typedef logic [INDEX_WIDTH-1:0]  idx_t;
  typedef logic [2:0]              axis_t;
  typedef logic [2:0]              reg_idx_t;
  typedef ext_t                    ext_arr_t [NUM_AXES];
  typedef idx_t                    idx_arr_t [NUM_AXES];

  // register map
  localparam reg_idx_t REG_RANK   = 3'd0;
  localparam reg_idx_t REG_BATCH  = 3'd1;
  localparam reg_idx_t REG_EXT1   = 3'd2;
  localparam reg_idx_t REG_EXT2   = 3'd3;
  localparam reg_idx_t REG_EXT3   = 3'd4;
  localparam reg_idx_t REG_EXT4   = 3'd5;
  localparam reg_idx_t REG_EXT5   = 3'd6;

  localparam logic [2:0] RANK_FOUR = 3'd4;
  localparam logic [2:0] RANK_FIVE = 3'd5;
  localparam logic [2:0] RANK_SIX  = 3'd6;

  localparam logic [TOTAL_WIDTH-1:0] ELEM_LIMIT = {1'b1, {INDEX_WIDTH{1'b0}}};

  // setup unit status toward the datapath
  typedef struct packed {
    logic busy;
    logic size_error;
  } setup_stat_t;

  // innermost source axis for a rank code; codes other than 5 and 6 fall back to rank 4
  function automatic axis_t last_axis(input logic [2:0] rank);
    axis_t r;
    case (rank)
      RANK_FIVE: r = 3'd4;
      RANK_SIX:  r = 3'd5;
      default:   r = 3'd3;
    endcase
    return r;
  endfunction

  // a zero extent counts as one
  function automatic ext_t eff_extent(input ext_t e);
    return (e == '0) ? ext_t'(1) : e;
  endfunction

endpackage

// ----- hdl/lsttr_stride.sv -----
// Setup unit: derives per-axis destination index steps and the size check
// from the extents after reset or a write to a listed register. Depends on lsttr_pkg.
`timescale 1ns / 1ps

module lsttr_stride (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  lsttr_pkg::axis_t      last_ax,
  input  lsttr_pkg::ext_arr_t   ext,
  output lsttr_pkg::setup_stat_t stat,
  output lsttr_pkg::idx_arr_t   delta
);

  typedef enum logic [1:0] {ST_IDLE, ST_CHAIN, ST_WRAP} state_t;

  localparam int PROD_W = lsttr_pkg::INDEX_WIDTH + lsttr_pkg::EXTENT_WIDTH;
  localparam int TPROD_W = lsttr_pkg::TOTAL_WIDTH + lsttr_pkg::EXTENT_WIDTH;

  state_t                               state;
  lsttr_pkg::axis_t                     step;
  lsttr_pkg::idx_t                      acc;
  logic [lsttr_pkg::TOTAL_WIDTH-1:0]    tot;
  lsttr_pkg::idx_t                      vsum;
  lsttr_pkg::idx_arr_t                  stride_q;
  lsttr_pkg::idx_arr_t                  dn_q;
  lsttr_pkg::idx_arr_t                  delta_q;
  logic                                 size_err;

  lsttr_pkg::axis_t                     lm1;
  lsttr_pkg::axis_t                     chain_ax;
  lsttr_pkg::axis_t                     jm1;
  lsttr_pkg::ext_t                      e_sel;
  logic [PROD_W-1:0]                    prod;
  logic [TPROD_W-1:0]                   tprod;
  logic [lsttr_pkg::TOTAL_WIDTH-1:0]    tsat;
  lsttr_pkg::idx_t                      wsum;

  // chain order: L-1 down to 1, then L, then 0; each stride is the product
  // of the extents visited before it
  always_comb begin
    lm1 = last_ax - 3'd1;
    if (step < lm1) begin
      chain_ax = lm1 - step;
    end else if (step == lm1) begin
      chain_ax = last_ax;
    end else begin
      chain_ax = 3'd0;
    end
    e_sel = ext[chain_ax];
    prod  = PROD_W'(acc) * PROD_W'(e_sel);
    tprod = TPROD_W'(tot) * TPROD_W'(e_sel);
    if (tprod > TPROD_W'(lsttr_pkg::ELEM_LIMIT)) begin
      tsat = lsttr_pkg::ELEM_LIMIT + 1'b1;
    end else begin
      tsat = tprod[lsttr_pkg::TOTAL_WIDTH-1:0];
    end
    jm1  = step - 3'd1;
    wsum = vsum + dn_q[step];
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= ST_CHAIN;
      step  <= '0;
      acc   <= lsttr_pkg::idx_t'(1);
      tot   <= lsttr_pkg::TOTAL_WIDTH'(1);
      vsum  <= '0;
    end else begin
      unique case (state)
        ST_CHAIN: begin
          stride_q[chain_ax] <= acc;
          // minus the span an inner axis covers once it wraps
          dn_q[chain_ax]     <= acc - prod[lsttr_pkg::INDEX_WIDTH-1:0];
          if (chain_ax == last_ax) begin
            delta_q[last_ax] <= acc;
          end
          acc <= prod[lsttr_pkg::INDEX_WIDTH-1:0];
          tot <= tsat;
          if (step == last_ax) begin
            size_err <= (tsat > lsttr_pkg::ELEM_LIMIT);
            state    <= ST_WRAP;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_WRAP: begin
          // step walks axis j from L down to 1; fills the step for axis j-1
          vsum         <= wsum;
          delta_q[jm1] <= stride_q[jm1] + wsum;
          if (step == 3'd1) begin
            state <= ST_IDLE;
          end else begin
            step <= jm1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.busy       = (state != ST_IDLE);
  assign stat.size_error = size_err;
  assign delta           = delta_q;

endmodule

// ----- hdl/lsttr_walk.sv -----
// Position counters and running destination index, one step per word.
// Depends on lsttr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "last_axis_to_second_transpose_addr_core_macros.svh"

module lsttr_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                clr,
  input  logic                adv,
  input  lsttr_pkg::axis_t    last_ax,
  input  lsttr_pkg::ext_arr_t ext,
  input  lsttr_pkg::idx_arr_t delta,
  output lsttr_pkg::idx_t     dest,
  output logic                wrap_all
);

  lsttr_pkg::ext_arr_t pos_q;
  lsttr_pkg::ext_arr_t pos_next;
  lsttr_pkg::idx_t     dest_q;
  lsttr_pkg::idx_t     dest_next;
  lsttr_pkg::idx_t     dsel;
  logic                carry;
  logic                at_end;
  logic                pos_zero;

  // innermost axis first; the first axis that does not wrap takes the step
  always_comb begin
    carry    = 1'b1;
    dsel     = '0;
    pos_zero = 1'b1;
    at_end   = 1'b0;
    for (int i = lsttr_pkg::NUM_AXES - 1; i >= 0; i--) begin
      pos_next[i] = pos_q[i];
      pos_zero    = pos_zero & (pos_q[i] == '0);
      if (3'(i) <= last_ax) begin
        at_end = ({1'b0, pos_q[i]} + 1'b1) >= {1'b0, ext[i]};
        if (carry) begin
          if (at_end) begin
            pos_next[i] = '0;
          end else begin
            pos_next[i] = pos_q[i] + 1'b1;
            dsel        = delta[i];
          end
        end
        carry = carry & at_end;
      end
    end
    wrap_all  = carry;
    dest_next = carry ? '0 : dest_q + dsel;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < lsttr_pkg::NUM_AXES; i++) begin
        pos_q[i] <= '0;
      end
      dest_q <= '0;
    end else if (adv) begin
      pos_q  <= pos_next;
      dest_q <= dest_next;
    end
  end

  assign dest = dest_q;

  `LSTTR_CHECK(a_clr_origin, clr |=> (dest_q == '0), "dest not cleared by write")
  `LSTTR_CHECK(a_wrap_origin, (adv && wrap_all && !clr) |=> (dest_q == '0), "dest not zero after last word")
  `LSTTR_CHECK(a_origin_dest, pos_zero |-> (dest_q == '0), "dest off origin at zero position")
  `LSTTR_CHECK(a_inner_range, pos_q[last_ax] < ext[last_ax], "inner position past extent")

endmodule

// ----- hdl/last_axis_to_second_transpose_addr_core.sv -----
// Top level of the channels-last to channels-first transpose address core.
// Depends on lsttr_pkg, lsttr_stride and lsttr_walk.
//
// Source words of a rank 4, 5 or 6 tensor enter on in_valid/in_ready in
// source row-major order. Each word leaves on out_valid/out_ready with its
// index in the destination tensor (last axis moved to position 1, batch axis
// first), last_element on the final word, and size_error when the active
// extents exceed 2^32 elements.
// The result is registered on accept; one word per cycle sustained while
// the setup unit is idle and out_ready stays high. The next word is taken
// while a result waits, as long as the receiver takes it in the same cycle;
// if out_ready is low while a result waits, the result holds and in_ready drops.
// Config: wr_en/wr_index/wr_data write rank and extents; a write to a listed
// register clears the position counters. After reset and after such a write
// the setup unit first multiplies out the strides and the size over the
// axes, then sums the wrap corrections, to build the index steps; in_ready
// stays low meanwhile.
// Reset: rank 4, all extents 1, counters at zero, output empty.
`timescale 1ns / 1ps

module last_axis_to_second_transpose_addr_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  lsttr_pkg::reg_idx_t               wr_index,
  input  logic [lsttr_pkg::CFG_WIDTH-1:0]   wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lsttr_pkg::WORD_WIDTH-1:0]  element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lsttr_pkg::INDEX_WIDTH-1:0] dest_index,
  output logic [lsttr_pkg::WORD_WIDTH-1:0]  element_out,
  output logic                              last_element,
  output logic                              size_error
);

  logic [2:0]             rank_q;
  lsttr_pkg::ext_arr_t    ext_q;
  lsttr_pkg::ext_arr_t    ext_eff;
  lsttr_pkg::axis_t       last_ax;
  lsttr_pkg::reg_idx_t    ext_sel;
  lsttr_pkg::setup_stat_t stat;
  lsttr_pkg::idx_arr_t    delta;
  lsttr_pkg::idx_t        dest;
  logic                   wrap_all;
  logic                   cfg_hit;
  logic                   adv;

  assign last_ax = lsttr_pkg::last_axis(rank_q);
  assign ext_sel = wr_index - 3'd1;
  assign cfg_hit = wr_en && (wr_index <= lsttr_pkg::REG_EXT5);

  always_comb begin
    for (int i = 0; i < lsttr_pkg::NUM_AXES; i++) begin
      ext_eff[i] = lsttr_pkg::eff_extent(ext_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_q <= lsttr_pkg::RANK_FOUR;
      for (int i = 0; i < lsttr_pkg::NUM_AXES; i++) begin
        ext_q[i] <= lsttr_pkg::ext_t'(1);
      end
    end else if (wr_en) begin
      unique case (wr_index)
        lsttr_pkg::REG_RANK: begin
          rank_q <= wr_data[2:0];
        end
        lsttr_pkg::REG_BATCH, lsttr_pkg::REG_EXT1, lsttr_pkg::REG_EXT2,
        lsttr_pkg::REG_EXT3, lsttr_pkg::REG_EXT4, lsttr_pkg::REG_EXT5: begin
          ext_q[ext_sel] <= wr_data[lsttr_pkg::EXTENT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lsttr_stride u_stride (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_hit),
    .last_ax (last_ax),
    .ext     (ext_eff),
    .stat    (stat),
    .delta   (delta)
  );

  lsttr_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .clr      (cfg_hit),
    .adv      (adv),
    .last_ax  (last_ax),
    .ext      (ext_eff),
    .delta    (delta),
    .dest     (dest),
    .wrap_all (wrap_all)
  );

  assign in_ready = !stat.busy && (!out_valid || out_ready);
  assign adv      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dest_index   <= dest;
      element_out  <= lsttr_pkg::WORD_WIDTH'(element[lsttr_pkg::ELEMENT_WIDTH-1:0]);
      last_element <= wrap_all;
      size_error   <= stat.size_error;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for last_axis_to_second_transpose_addr_core.
// Predicts dest_index, last_element and size_error for each word in the bench itself.
// Depends on lsttr_pkg and the core RTL only; runs directed tests, random phases and an output stall.
`timescale 1ns / 1ps

module tb_top;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          LONG_STALL     = 300;
  localparam logic [7:0]  ALL_REGS       = 8'h7F;
  localparam logic [7:0]  ALL_WITH_SPARE = 8'hFF;
  localparam logic [7:0]  SPARE_ONLY     = 8'h80;
  localparam longint unsigned WORD_MASK      = 64'hFFFF_FFFF;
  localparam longint unsigned OVERSIZE_LIMIT = 64'h1_0000_0000;

  typedef struct {
    logic [31:0] dest;
    logic [31:0] elem;
    logic        last;
    logic        err;
  } dest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  lsttr_pkg::reg_idx_t wr_index = lsttr_pkg::REG_RANK;
  logic [15:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] element = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] dest_index;
  logic [31:0] element_out;
  logic        last_element;
  logic        size_error;

  // bench copy of the configuration and the source position counters
  logic [2:0]  cfg_rank;
  logic [15:0] cfg_extent [6];
  logic [15:0] src_pos [6];

  dest_word_t  transposed_q [$];
  dest_word_t  want;
  bit          offering = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_requests = 0;
  int          stalls_seen = 0;
  int          stall_left = 0;
  int          errors = 0;
  int          words_checked = 0;
  int          settings = 0;
  int          cycles = 0;

  last_axis_to_second_transpose_addr_core DUT (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .element(element),
    .out_valid(out_valid), .out_ready(out_ready),
    .dest_index(dest_index), .element_out(element_out),
    .last_element(last_element), .size_error(size_error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int active_axes();
    case (cfg_rank)
      lsttr_pkg::RANK_FIVE: return 5;
      lsttr_pkg::RANK_SIX:  return 6;
      default:              return 4;
    endcase
  endfunction

  function automatic longint unsigned axis_extent(input int a);
    return (cfg_extent[a] == 16'd0) ? 64'd1 : longint'(cfg_extent[a]);
  endfunction

  // element count of the active tensor, saturated just above 2^32
  function automatic longint unsigned tensor_words();
    longint unsigned total;
    int i;
    total = 1;
    for (i = 0; i < active_axes(); i++) begin
      total = total * axis_extent(i);
      if (total > OVERSIZE_LIMIT) total = OVERSIZE_LIMIT + 1;
    end
    return total;
  endfunction

  // destination index of the word at the current source position, then step the counters
  task automatic predict_word(input logic [31:0] w, output dest_word_t r);
    longint unsigned inner, stride, dest;
    int last, i;
    bit carry;
    last = active_axes() - 1;
    inner = 0;
    stride = 1;
    // axes 1..last-1 keep their order behind the moved axis
    for (i = last - 1; i >= 1; i--) begin
      inner = (inner + ((longint'(src_pos[i]) * stride) & WORD_MASK)) & WORD_MASK;
      stride = (stride * axis_extent(i)) & WORD_MASK;
    end
    dest = (inner + ((longint'(src_pos[last]) * stride) & WORD_MASK)) & WORD_MASK;
    stride = (stride * axis_extent(last)) & WORD_MASK;
    dest = (dest + ((longint'(src_pos[0]) * stride) & WORD_MASK)) & WORD_MASK;
    carry = 1;
    for (i = last; i >= 0 && carry; i--) begin
      if (longint'(src_pos[i]) + 1 >= axis_extent(i)) begin
        src_pos[i] = '0;
      end else begin
        src_pos[i] = src_pos[i] + 16'd1;
        carry = 0;
      end
    end
    r.dest = dest[31:0];
    r.elem = w;
    r.last = carry;
    r.err  = tensor_words() > OVERSIZE_LIMIT;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    if (offering) in_valid <= 1'b0;
    offering = 0;
    while (transposed_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    int gap;
    dest_word_t r;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= w;
    offering = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w, r);
    transposed_q.push_back(r);
  endtask

  // writes the selected registers back to back, once the core has drained
  task automatic program_regs(input logic [7:0] sel, input logic [2:0] rank_code,
                              input logic [15:0] b, e1, e2, e3, e4, e5);
    logic [15:0] vals [8];
    logic [31:0] noise;
    lsttr_pkg::reg_idx_t idx;
    int i;
    wait_drained();
    noise = $urandom;
    vals[0] = {noise[12:0], rank_code};  // upper bits are don't-care for rank
    vals[1] = b;
    vals[2] = e1;
    vals[3] = e2;
    vals[4] = e3;
    vals[5] = e4;
    vals[6] = e5;
    vals[7] = noise[31:16];
    for (i = 0; i < 8; i++) begin
      if (sel[i]) begin
        idx = lsttr_pkg::reg_idx_t'(i);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= vals[i];
        @(posedge clk);
        if (idx == lsttr_pkg::REG_RANK) cfg_rank = vals[i][2:0];
        else if (idx <= lsttr_pkg::REG_EXT5) cfg_extent[idx - 1] = vals[i];
        if (idx <= lsttr_pkg::REG_EXT5) src_pos = '{default: '0};
      end
    end
    wr_en <= 1'b0;
    settings++;
  endtask

  task automatic test_reset_state();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hA5A5_5A5A);
  endtask

  // odd rank codes fall back to four axes
  task automatic test_rank_select();
    program_regs(ALL_REGS, 3'd0, 16'd1, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    program_regs(ALL_REGS, 3'd7, 16'd1, 16'd1, 16'd1, 16'd1, 16'd3, 16'd3);
    send_word(32'h8000_0001);
    program_regs(ALL_REGS, lsttr_pkg::RANK_FIVE, 16'd1, 16'd2, 16'd1, 16'd1, 16'd2,
                 16'd1);
    repeat (4) send_word(pick_word());
    program_regs(ALL_REGS, lsttr_pkg::RANK_SIX, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
                 16'd3);
    repeat (3) send_word(pick_word());
  endtask

  task automatic test_zero_extent();
    program_regs(ALL_REGS, lsttr_pkg::RANK_FOUR, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0,
                 16'd0);
    send_word(32'h0123_4567);
    send_word(32'hFEDC_BA98);
  endtask

  task automatic test_oversize();
    program_regs(ALL_REGS, lsttr_pkg::RANK_SIX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    // just under 2^32 elements: no error flag
    program_regs(ALL_REGS, lsttr_pkg::RANK_FOUR, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1,
                 16'd1, 16'd1);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
  endtask

  // a listed write restarts the counters, the spare index leaves them alone
  task automatic test_write_clears();
    program_regs(ALL_REGS, lsttr_pkg::RANK_FOUR, 16'd1, 16'd1, 16'd1, 16'd4, 16'd1,
                 16'd1);
    send_word(pick_word());
    send_word(pick_word());
    program_regs(ALL_REGS, lsttr_pkg::RANK_FOUR, 16'd1, 16'd1, 16'd1, 16'd4, 16'd1,
                 16'd1);
    send_word(pick_word());
    send_word(pick_word());
    program_regs(SPARE_ONLY, lsttr_pkg::RANK_FOUR, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1,
                 16'd1);
    send_word(pick_word());
    send_word(pick_word());
  endtask

  task automatic run_random_phase(input int s_pct, input int r_pct, input int quota);
    logic [15:0] ex [6];
    logic [2:0] rk;
    longint unsigned words;
    int sent, n, i, a;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < quota) begin
      rk = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(4, 6));
      if ($urandom_range(0, 3) != 0) begin
        // small tensor so that whole passes and last_element come often
        for (a = 0; a < 6; a++) ex[a] = 16'($urandom_range(0, 2));
        a = $urandom_range(0, 5);
        ex[a] = 16'($urandom_range(1, 6));
      end else begin
        for (a = 0; a < 6; a++) begin
          case ($urandom_range(0, 3))
            0:       ex[a] = 16'hFFFF;
            1:       ex[a] = 16'($urandom);
            2:       ex[a] = 16'($urandom_range(0, 1));
            default: ex[a] = 16'($urandom_range(2, 8));
          endcase
        end
      end
      program_regs(($urandom_range(0, 7) == 0) ? ALL_WITH_SPARE : ALL_REGS, rk,
                   ex[0], ex[1], ex[2], ex[3], ex[4], ex[5]);
      words = tensor_words();
      if (words <= 64) n = int'(words) + $urandom_range(0, int'(words));
      else n = $urandom_range(8, 24);
      for (i = 0; i < n; i++) send_word(pick_word());
      sent += n;
    end
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_backpressure();
    int i;
    program_regs(ALL_REGS, lsttr_pkg::RANK_FOUR, 16'd2, 16'd3, 16'd2, 16'd2, 16'd1,
                 16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    for (i = 0; i < 60; i++) send_word(pick_word());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stalls_seen != stall_requests) begin
      stalls_seen <= stall_requests;
      stall_left  <= LONG_STALL;
      out_ready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (transposed_q.size() == 0) begin
        $display("%0t unexpected word: dest_index %h element_out %h", $time, dest_index,
                 element_out);
        errors++;
      end else begin
        want = transposed_q.pop_front();
        words_checked++;
        if (dest_index !== want.dest) begin
          $display("%0t dest_index: expected %h, actual %h", $time, want.dest, dest_index);
          errors++;
        end
        if (element_out !== want.elem) begin
          $display("%0t element_out: expected %h, actual %h", $time, want.elem, element_out);
          errors++;
        end
        if (last_element !== want.last) begin
          $display("%0t last_element: expected %b, actual %b", $time, want.last,
                   last_element);
          errors++;
        end
        if (size_error !== want.err) begin
          $display("%0t size_error: expected %b, actual %b", $time, want.err, size_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, transposed_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cfg_rank = lsttr_pkg::RANK_FOUR;
    cfg_extent = '{default: 16'd1};
    src_pos = '{default: '0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // let the setup pass after reset finish before the first write
    repeat (12) @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 83;
    test_reset_state();
    test_rank_select();
    test_zero_extent();
    test_oversize();
    test_write_clears();
    run_random_phase(37, 83, 230);
    run_random_phase(83, 37, 230);
    test_backpressure();
    run_random_phase(0, 0, 230);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d words under %0d register settings (ranks 4-6, odd rank codes,",
             words_checked, settings);
    $display("zero and full-scale extents, oversized tensors, a %0d-cycle output stall).",
             LONG_STALL);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
